FILE: rtl/core/sensor_command_packet_framer_unit_defines.svh
// Assertion macros for the framer modules, used by scpf_emit.
`ifndef SENSOR_COMMAND_PACKET_FRAMER_UNIT_DEFINES_SVH
`define SENSOR_COMMAND_PACKET_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every edge outside reset.
`define SCPF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scpf assertion failed");

// Next-cycle implication, checked on every edge outside reset.
`define SCPF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scpf assertion failed");

`endif

FILE: rtl/core/scpf_pkg.sv
// Types and constants shared by the command packet framer modules.
`default_nettype none

package scpf_pkg;

  localparam int unsigned MAX_RESULTS = 12;
  localparam int unsigned RES_CNT_W   = 4;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [15:0] LEN_EXTRA      = 16'd3;
  localparam logic [7:0]  MIN_RX         = 8'd12;
  localparam logic [7:0]  RX_COUNT_MAX   = 8'hFF;
  localparam logic [7:0]  LEN_HI_OFFSET  = 8'd7;
  localparam logic [7:0]  LEN_LO_OFFSET  = 8'd8;
  localparam logic [7:0]  CONFIRM_OFFSET = 8'd9;

  localparam logic [RES_CNT_W-1:0] START_WORDS     = 4'd10;
  localparam logic [RES_CNT_W-1:0] START_WORDS_CHK = 4'd12;
  localparam logic [RES_CNT_W-1:0] PAYLOAD_WORDS_CHK = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_WORD    = 1'd1;

  localparam logic [31:0] DEVICE_ADDRESS_RST = 32'hFFFF_FFFF;
  localparam logic [15:0] HEADER_WORD_RST    = 16'hEF01;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_RX      = 2'd2
  } action_t;

  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // Result words that one accepted item produces, oldest in entry 0.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [RES_CNT_W-1:0]        cnt;
    kind_t                       kind;
    logic                        chk;
    logic [7:0]                  confirmation;
    logic [15:0]                 data_size;
    logic                        receive_error;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/core/sensor_command_packet_framer_unit.sv
// Command packet framer for a serial sensor module: takes start, payload and
// received words and gives frame words and response summaries. A start word
// yields ten frame words, twelve when the payload is empty; a payload word
// yields one, or three with the checksum after the last payload word; a
// received word yields one summary at the end of a response and nothing
// otherwise. Output words leave at one per cycle while out_ready allows, via
// a single job register feeding the output register; an item has at most
// twelve results; a new item is taken in the cycle the old last word moves on.
// Configuration is written via the cfg port; the user must do so only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module sensor_command_packet_framer_unit #(
  parameter int unsigned MAX_PAYLOAD = 243
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [7:0]                     in_packet_id,
  input  wire logic [7:0]                     in_instruction,
  input  wire logic [7:0]                     in_payload_size,
  input  wire logic [7:0]                     in_byte_value,
  input  wire logic                           in_rx_end,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_kind,
  output logic [7:0]                          out_frame_byte,
  output logic                                out_frame_last,
  output logic [7:0]                          out_confirmation,
  output logic [15:0]                         out_response_data_size,
  output logic                                out_receive_error,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  scpf_pkg::job_t job;
  logic           job_free;
  logic           in_fire;
  logic           cfg_fire;

  assign in_ready  = job_free;
  assign in_fire   = in_valid && job_free;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  scpf_ingest #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_ingest (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_action      (in_action),
    .in_packet_id   (in_packet_id),
    .in_instruction (in_instruction),
    .in_payload_size(in_payload_size),
    .in_byte_value  (in_byte_value),
    .in_rx_end      (in_rx_end),
    .cfg_fire       (cfg_fire),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .job            (job)
  );

  scpf_emit u_emit (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_fire               (in_fire),
    .job_in                (job),
    .job_free              (job_free),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_frame_byte        (out_frame_byte),
    .out_frame_last        (out_frame_last),
    .out_confirmation      (out_confirmation),
    .out_response_data_size(out_response_data_size),
    .out_receive_error     (out_receive_error)
  );

endmodule

`default_nettype wire

FILE: rtl/core/scpf_ingest.sv
// Input decode, framing state and configuration registers; builds the result job.
`default_nettype none

module scpf_ingest #(
  parameter int unsigned MAX_PAYLOAD = 243
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_fire,
  input  wire logic [1:0]                     in_action,
  input  wire logic [7:0]                     in_packet_id,
  input  wire logic [7:0]                     in_instruction,
  input  wire logic [7:0]                     in_payload_size,
  input  wire logic [7:0]                     in_byte_value,
  input  wire logic                           in_rx_end,
  input  wire logic                           cfg_fire,
  input  wire logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output scpf_pkg::job_t                      job
);

  logic [31:0] device_address_r;
  logic [15:0] header_word_r;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  rx_count_r, rx_count_nxt;
  logic [15:0] rx_length_r, rx_length_nxt;
  logic [7:0]  rx_confirm_r, rx_confirm_nxt;

  logic [7:0]  size_c;
  logic [15:0] len;
  logic [15:0] start_sum;
  logic [15:0] pay_sum;
  logic [7:0]  rx_inc;
  logic [15:0] rx_len_upd;
  logic [7:0]  rx_conf_upd;
  logic        rx_short;
  logic [15:0] data_size;
  scpf_pkg::action_t act;

  assign act       = scpf_pkg::action_t'(in_action);
  assign size_c    = (in_payload_size > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : in_payload_size;
  assign len       = {8'd0, size_c} + scpf_pkg::LEN_EXTRA;
  assign start_sum = len + {8'd0, in_instruction} + {8'd0, in_packet_id};
  assign pay_sum   = running_sum_r + {8'd0, in_byte_value};
  assign rx_inc    = (rx_count_r == scpf_pkg::RX_COUNT_MAX) ? rx_count_r : rx_count_r + 8'd1;

  // The offset is that of the byte now arriving, i.e. the count before it.
  always_comb begin
    rx_len_upd  = rx_length_r;
    rx_conf_upd = rx_confirm_r;
    if (rx_count_r == scpf_pkg::LEN_HI_OFFSET) begin
      rx_len_upd = {in_byte_value, rx_length_r[7:0]};
    end else if (rx_count_r == scpf_pkg::LEN_LO_OFFSET) begin
      rx_len_upd = {rx_length_r[15:8], in_byte_value};
    end else if (rx_count_r == scpf_pkg::CONFIRM_OFFSET) begin
      rx_conf_upd = in_byte_value;
    end
  end

  assign rx_short  = rx_inc < scpf_pkg::MIN_RX;
  assign data_size = (rx_len_upd >= scpf_pkg::LEN_EXTRA) ? rx_len_upd - scpf_pkg::LEN_EXTRA
                                                           : 16'd0;

  always_comb begin
    job              = '0;
    job.kind         = scpf_pkg::KIND_FRAME;
    bytes_left_nxt   = bytes_left_r;
    running_sum_nxt  = running_sum_r;
    rx_count_nxt     = rx_count_r;
    rx_length_nxt    = rx_length_r;
    rx_confirm_nxt   = rx_confirm_r;
    unique case (act)
      scpf_pkg::ACT_START: begin
        job.bytes[0]    = header_word_r[15:8];
        job.bytes[1]    = header_word_r[7:0];
        job.bytes[2]    = device_address_r[31:24];
        job.bytes[3]    = device_address_r[23:16];
        job.bytes[4]    = device_address_r[15:8];
        job.bytes[5]    = device_address_r[7:0];
        job.bytes[6]    = in_packet_id;
        job.bytes[7]    = len[15:8];
        job.bytes[8]    = len[7:0];
        job.bytes[9]    = in_instruction;
        job.bytes[10]   = start_sum[15:8];
        job.bytes[11]   = start_sum[7:0];
        job.chk         = (size_c == 8'd0);
        job.cnt         = job.chk ? scpf_pkg::START_WORDS_CHK : scpf_pkg::START_WORDS;
        bytes_left_nxt  = size_c;
        running_sum_nxt = start_sum;
        rx_count_nxt    = 8'd0;
        rx_length_nxt   = 16'd0;
        rx_confirm_nxt  = 8'd0;
      end
      scpf_pkg::ACT_PAYLOAD: begin
        // A payload word with nothing expected is dropped without a result.
        if (bytes_left_r != 8'd0) begin
          job.bytes[0]    = in_byte_value;
          job.bytes[1]    = pay_sum[15:8];
          job.bytes[2]    = pay_sum[7:0];
          job.chk         = (bytes_left_r == 8'd1);
          job.cnt         = job.chk ? scpf_pkg::PAYLOAD_WORDS_CHK : 4'd1;
          bytes_left_nxt  = bytes_left_r - 8'd1;
          running_sum_nxt = pay_sum;
        end
      end
      scpf_pkg::ACT_RX: begin
        if (in_rx_end) begin
          job.kind          = scpf_pkg::KIND_SUMMARY;
          job.cnt           = 4'd1;
          job.receive_error = rx_short;
          job.confirmation  = rx_short ? 8'd0 : rx_conf_upd;
          job.data_size     = rx_short ? 16'd0 : data_size;
          rx_count_nxt      = 8'd0;
          rx_length_nxt     = 16'd0;
          rx_confirm_nxt    = 8'd0;
        end else begin
          rx_count_nxt   = rx_inc;
          rx_length_nxt  = rx_len_upd;
          rx_confirm_nxt = rx_conf_upd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= scpf_pkg::DEVICE_ADDRESS_RST;
      header_word_r    <= scpf_pkg::HEADER_WORD_RST;
      bytes_left_r     <= '0;
      running_sum_r    <= '0;
      rx_count_r       <= '0;
      rx_length_r      <= '0;
      rx_confirm_r     <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          scpf_pkg::REG_DEVICE_ADDRESS: device_address_r <= cfg_data;
          scpf_pkg::REG_HEADER_WORD:    header_word_r    <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        bytes_left_r  <= bytes_left_nxt;
        running_sum_r <= running_sum_nxt;
        rx_count_r    <= rx_count_nxt;
        rx_length_r   <= rx_length_nxt;
        rx_confirm_r  <= rx_confirm_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/scpf_emit.sv
// Job register and output register: sends the words of one job, one per cycle while out_ready allows.
`default_nettype none

`include "sensor_command_packet_framer_unit_defines.svh"

module scpf_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire scpf_pkg::job_t job_in,
  output logic                job_free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_kind,
  output logic [7:0]          out_frame_byte,
  output logic                out_frame_last,
  output logic [7:0]          out_confirmation,
  output logic [15:0]         out_response_data_size,
  output logic                out_receive_error
);

  scpf_pkg::job_t                job_r;
  logic [scpf_pkg::RES_CNT_W-1:0] cnt_r;
  logic                           out_valid_r;
  logic                           kind_r;
  logic [7:0]                     frame_byte_r;
  logic                           frame_last_r;
  logic [7:0]                     confirmation_r;
  logic [15:0]                    data_size_r;
  logic                           receive_error_r;
  logic                           move;
  logic                           send;
  logic                           load;

  // The output register can take a word when empty or being drained.
  assign move     = !out_valid_r || out_ready;
  assign send     = move && (cnt_r != '0);
  assign job_free = (cnt_r == '0) || ((cnt_r == 4'd1) && move);
  assign load     = in_fire && (job_in.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (move) begin
        out_valid_r <= (cnt_r != '0);
      end
      if (load) begin
        cnt_r <= job_in.cnt;
      end else if (send) begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      kind_r          <= job_r.kind;
      frame_byte_r    <= job_r.bytes[0];
      frame_last_r    <= job_r.chk && (cnt_r == 4'd1);
      confirmation_r  <= job_r.confirmation;
      data_size_r     <= job_r.data_size;
      receive_error_r <= job_r.receive_error;
    end
    if (load) begin
      job_r <= job_in;
    end else if (send) begin
      job_r.bytes <= {8'd0, job_r.bytes[scpf_pkg::MAX_RESULTS-1:1]};
    end
  end

  assign out_valid              = out_valid_r;
  assign out_kind               = kind_r;
  assign out_frame_byte         = frame_byte_r;
  assign out_frame_last         = frame_last_r;
  assign out_confirmation       = confirmation_r;
  assign out_response_data_size = data_size_r;
  assign out_receive_error      = receive_error_r;

  `SCPF_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= 4'(scpf_pkg::MAX_RESULTS))
  `SCPF_ASSERT_NEXT(a_send_fills, send, out_valid_r)
  `SCPF_ASSERT_IMPL(a_last_is_frame, out_valid_r && frame_last_r, !kind_r)
  `SCPF_ASSERT_IMPL(a_summary_single, (cnt_r != '0) && job_r.kind, cnt_r == 4'd1)

endmodule

`default_nettype wire
